[rtl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// Used by the controller, the datapath and the top level; depends on nothing.
package tcw_pkg;

   localparam int IDX_W = 11;
   localparam int POS_W = 11;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_NONE  = 2'd3;

   localparam logic [7:0] CODE_TAB     = 8'd9;
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_RETURN  = 8'd13;
   localparam logic [7:0] CODE_SPACE   = 8'd32;
   localparam logic [7:0] RESET_COLOR  = 8'd7;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic do_write;
      logic do_move;
      logic scroll_start;
      logic scroll_end;
      logic clear_start;
      logic sweep_step;
      logic fill_reset;
      logic read_issue;
      logic load_result;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_put;
      logic req_move;
      logic req_clear;
      logic req_read;
      logic adv_scroll;
      logic nl_scroll;
      logic tab_last;
      logic tab_more;
      logic sweep_done;
   } status_type;

endpackage

[rtl/tcw_ctrl.sv]
// Controller state machine of the text console writer.
// Depends on tcw_pkg for the command and status structs.
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_WRITE  = 4'd2;
   localparam logic [3:0] S_MOVE   = 4'd3;
   localparam logic [3:0] S_SCROLL = 4'd4;
   localparam logic [3:0] S_CLEAR  = 4'd5;
   localparam logic [3:0] S_READ   = 4'd6;
   localparam logic [3:0] S_RDATA  = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       done;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      done         = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            // Power-on clearing pass over the whole grid.
            cmd.sweep_step = 1'b1;
            cmd.fill_reset = 1'b1;
            if (status.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               priority if (status.req_put) begin
                  state_in = S_WRITE;
               end else if (status.req_clear) begin
                  cmd.clear_start = 1'b1;
                  state_in = S_CLEAR;
               end else if (status.req_read) begin
                  state_in = S_READ;
               end else if (status.req_move) begin
                  state_in = S_MOVE;
               end
            end
         end
         S_WRITE: begin
            cmd.do_write = 1'b1;
            if (status.adv_scroll) begin
               cmd.scroll_start = 1'b1;
               state_in = S_SCROLL;
            end else if (status.tab_last) begin
               done = 1'b1;
            end
         end
         S_MOVE: begin
            cmd.do_move = 1'b1;
            if (status.nl_scroll) begin
               cmd.scroll_start = 1'b1;
               state_in = S_SCROLL;
            end else begin
               done = 1'b1;
            end
         end
         S_SCROLL: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_done) begin
               cmd.scroll_end = 1'b1;
               if (status.tab_more) begin
                  state_in = S_WRITE;
               end else begin
                  done = 1'b1;
               end
            end
         end
         S_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_done) begin
               done = 1'b1;
            end
         end
         S_READ: begin
            cmd.read_issue = 1'b1;
            state_in = S_RDATA;
         end
         S_RDATA: begin
            done = 1'b1;
         end
         S_RESP: begin
            done = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // The result goes to the output register as soon as it is free.
      if (done) begin
         if (out_free) begin
            cmd.load_result = 1'b1;
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end else begin
            state_in = S_RESP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/tcw_dp.sv]
// Datapath of the text console writer: cell memories, cursor, scroll base,
// sweep counter and result register. Depends on tcw_pkg.
module tcw_dp
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [1:0]       req_func,
   input  logic [7:0]       req_char,
   input  logic [IDX_W-1:0] req_index,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   output logic [POS_W-1:0] rsp_cursor,
   output logic [7:0]       rsp_char,
   output logic [7:0]       rsp_color
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int SW    = ((AW > IDX_W) ? AW : IDX_W) + 1;
   localparam int LW    = (AW > POS_W) ? AW : POS_W;
   localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);

   // Grid memories, addressed physically; the ring base top_ff marks row 0.
   logic [7:0] char_mem_ff  [CELLS];
   logic [7:0] color_mem_ff [CELLS];
   logic [7:0] rd_char_ff, rd_color_ff;

   logic [1:0]       func_ff;
   logic [7:0]       code_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             read_ok_ff;
   logic [2:0]       tab_ff, tab_in;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] lin_ff, lin_in;
   logic [AW-1:0] top_ff, top_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [AW-1:0] last_ff, last_in;
   logic [7:0]    fill_ff;

   logic          col_end, row_end, req_nl, req_cr;
   logic [AW:0]   cur_sum, top_next;
   logic [AW-1:0] cur_phys, rd_phys, wr_addr;
   logic [SW-1:0] rd_sum;
   logic [LW-1:0] lin_wide;
   logic [7:0]    wr_char, wr_color;
   logic          char_we, color_we;

   assign col_end = (col_ff == CW'(COLUMNS - 1));
   assign row_end = (row_ff == RW'(ROWS - 1));
   assign req_nl  = (req_char == CODE_NEWLINE);
   assign req_cr  = (req_char == CODE_RETURN);

   always_comb begin
      status = '0;
      unique case (req_func)
         FUNC_WRITE: begin
            status.req_put  = !req_nl && !req_cr;
            status.req_move = req_nl || req_cr;
         end
         FUNC_CLEAR: status.req_clear = 1'b1;
         FUNC_READ:  status.req_read  = 1'b1;
         FUNC_NONE:  status.req_move  = 1'b1;
      endcase
      status.adv_scroll = col_end && row_end;
      status.nl_scroll  = (func_ff == FUNC_WRITE) && (code_ff == CODE_NEWLINE) && row_end;
      status.tab_last   = (tab_ff == 3'd1);
      status.tab_more   = (tab_ff != 3'd0);
      status.sweep_done = (sweep_ff == last_ff);
   end

   // Logical to physical address: add the ring base and wrap once.
   always_comb begin
      cur_sum = {1'b0, lin_ff} + {1'b0, top_ff};
      if (cur_sum >= (AW + 1)'(CELLS)) begin
         cur_sum = cur_sum - (AW + 1)'(CELLS);
      end
      cur_phys = cur_sum[AW-1:0];
      rd_sum = SW'(idx_ff) + SW'(top_ff);
      if (rd_sum >= SW'(CELLS)) begin
         rd_sum = rd_sum - SW'(CELLS);
      end
      rd_phys  = rd_sum[AW-1:0];
      top_next = {1'b0, top_ff} + (AW + 1)'(COLUMNS);
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      lin_in   = lin_ff;
      top_in   = top_ff;
      sweep_in = sweep_ff;
      last_in  = last_ff;
      tab_in   = tab_ff;
      if (cmd.load_item) begin
         if (req_func == FUNC_WRITE && !req_nl && !req_cr) begin
            // Tab stops every four columns: the low two column bits.
            tab_in = (req_char == CODE_TAB) ? (3'd4 - {1'b0, col_ff[1:0]}) : 3'd1;
         end else begin
            tab_in = 3'd0;
         end
      end
      if (cmd.clear_start) begin
         col_in   = '0;
         row_in   = '0;
         lin_in   = '0;
         top_in   = '0;
         sweep_in = '0;
         last_in  = AW'(CELLS - 1);
      end else if (cmd.do_write) begin
         tab_in = tab_ff - 3'd1;
         if (col_end) begin
            col_in = '0;
            if (row_end) begin
               lin_in = LAST_BASE;
            end else begin
               row_in = row_ff + RW'(1);
               lin_in = lin_ff + AW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
            lin_in = lin_ff + AW'(1);
         end
      end else if (cmd.do_move && func_ff == FUNC_WRITE) begin
         if (code_ff == CODE_NEWLINE) begin
            col_in = '0;
            if (row_end) begin
               lin_in = LAST_BASE;
            end else begin
               row_in = row_ff + RW'(1);
               lin_in = lin_ff - AW'(col_ff) + AW'(COLUMNS);
            end
         end else if (code_ff == CODE_RETURN) begin
            col_in = '0;
            lin_in = lin_ff - AW'(col_ff);
         end
      end
      if (cmd.scroll_start) begin
         sweep_in = top_ff;
         last_in  = top_ff + AW'(COLUMNS - 1);
      end else if (cmd.sweep_step) begin
         sweep_in = sweep_ff + AW'(1);
      end
      if (cmd.scroll_end) begin
         top_in = (top_next == (AW + 1)'(CELLS)) ? '0 : top_next[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         lin_ff   <= '0;
         top_ff   <= '0;
         sweep_ff <= '0;
         last_ff  <= AW'(CELLS - 1);
         tab_ff   <= '0;
         fill_ff  <= RESET_COLOR;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         lin_ff   <= lin_in;
         top_ff   <= top_in;
         sweep_ff <= sweep_in;
         last_ff  <= last_in;
         tab_ff   <= tab_in;
         if (csr_wr_en) begin
            fill_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff    <= req_func;
         code_ff    <= req_char;
         idx_ff     <= req_index;
         read_ok_ff <= (SW'(req_index) < SW'(CELLS));
      end
   end

   always_comb begin
      wr_addr  = cmd.sweep_step ? sweep_ff : cur_phys;
      wr_char  = '0;
      wr_color = cmd.fill_reset ? RESET_COLOR : fill_ff;
      char_we  = cmd.sweep_step || cmd.do_write;
      color_we = cmd.sweep_step;
      if (!cmd.sweep_step) begin
         wr_char = (code_ff == CODE_TAB) ? CODE_SPACE : code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem_ff[wr_addr] <= wr_char;
      end
      if (color_we) begin
         color_mem_ff[wr_addr] <= wr_color;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_issue) begin
         rd_char_ff  <= char_mem_ff[rd_phys];
         rd_color_ff <= color_mem_ff[rd_phys];
      end
   end

   assign lin_wide = LW'(lin_in);

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_cursor <= lin_wide[POS_W-1:0];
         if (func_ff == FUNC_READ && read_ok_ff) begin
            rsp_char  <= rd_char_ff;
            rsp_color <= rd_color_ff;
         end else begin
            rsp_char  <= '0;
            rsp_color <= '0;
         end
      end
   end

endmodule

[rtl/text_console_writer.sv]
// Top level of the text console writer.
// Instantiates tcw_ctrl and tcw_dp; depends on tcw_pkg.
//
// A request transfer carries a function in req_tuser (write character,
// clear screen, read cell or none) with the character and cell index in req_tdata.
// Each request gives exactly one response transfer: the linear cursor
// position and, for a read, the character and color bytes of the cell.
// csr_wr_en/csr_wr_data set the fill color used by clear and by scrolling.
// A character goes through the write state and a newline or return through
// the move state; a tab writes its spaces one after another up to the next
// tab stop; a read passes through the read and read data states; a clear
// sweeps every cell. A write or newline that moves past the last row also
// clears the new bottom row; the grid is a ring of rows, so a scroll moves
// no data. A new request is accepted only in the idle state, so the block
// finishes one request before it takes the next. After reset the block
// runs a clearing pass over the whole grid with req_tready low. A stalled
// response is held in its register; the next request is accepted and
// worked on meanwhile, and its result waits until the register is free.
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // char_code[7:0], cell_index[18:8], zero[23:19]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // cursor_pos[10:0], read_char[18:11],
                                   // read_color[26:19], zero[31:27]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   cmd_type          cmd;
   status_type       status;
   logic [POS_W-1:0] rsp_cursor;
   logic [7:0]       rsp_char, rsp_color;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcw_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_func    (req_tuser),
      .req_char    (req_tdata[7:0]),
      .req_index   (req_tdata[18:8]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_cursor  (rsp_cursor),
      .rsp_char    (rsp_char),
      .rsp_color   (rsp_color)
   );

   assign rsp_tdata = {5'b0, rsp_color, rsp_char, rsp_cursor};

endmodule

[dv/text_console_checker.sv]
// Scoreboard for the text console writer: watches the request, response and
// fill color ports, keeps its own copy of the character grid and cursor, and
// compares every response transfer with the predicted one. Depends on tcw_pkg.
`timescale 1ns / 100ps

module text_console_checker
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,  // char_code[7:0], cell_index[18:8], zero[23:19]
   input  logic [1:0]  req_tuser,  // func[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,  // cursor_pos[10:0], read_char[18:11],
                                   // read_color[26:19], zero[31:27]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output int          pending,
   output int          fail_count
);

   localparam int CELLS    = COLUMNS * ROWS;
   localparam int TAB_STOP = 4;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [7:0]       glyph;
      logic [7:0]       tint;
   } console_reply_type;

   logic [7:0]        glyph_mem [0:CELLS-1];
   logic [7:0]        tint_mem  [0:CELLS-1];
   int unsigned       cur_col;
   int unsigned       cur_row;
   logic [7:0]        fill_tint;
   console_reply_type console_replies [$];
   int                mismatches = 0;

   function automatic void blank_grid();
      for (int i = 0; i < CELLS; i++) begin
         glyph_mem[i] = 8'h00;
         tint_mem[i]  = fill_tint;
      end
      cur_col = 0;
      cur_row = 0;
   endfunction

   // The grid moves up one row; the new bottom row is blank in the fill color.
   function automatic void scroll_grid();
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
         glyph_mem[i] = glyph_mem[i + COLUMNS];
         tint_mem[i]  = tint_mem[i + COLUMNS];
      end
      for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
         glyph_mem[i] = 8'h00;
         tint_mem[i]  = fill_tint;
      end
      cur_row = ROWS - 1;
   endfunction

   function automatic void wrap_cursor();
      if (cur_col >= COLUMNS) begin
         cur_col = 0;
         cur_row++;
      end
      if (cur_row >= ROWS) scroll_grid();
   endfunction

   // Only the character byte is stored; the cell keeps its color.
   function automatic void put_glyph(logic [7:0] code);
      glyph_mem[cur_row * COLUMNS + cur_col] = code;
      cur_col++;
      wrap_cursor();
   endfunction

   function automatic void apply_code(logic [7:0] code);
      int unsigned spaces;
      if (code == CODE_NEWLINE) begin
         cur_col = 0;
         cur_row++;
         wrap_cursor();
      end else if (code == CODE_RETURN) begin
         cur_col = 0;
      end else if (code == CODE_TAB) begin
         // The space count is fixed before the first space is written.
         spaces = TAB_STOP - (cur_col % TAB_STOP);
         repeat (spaces) put_glyph(CODE_SPACE);
      end else begin
         put_glyph(code);
      end
   endfunction

   function automatic console_reply_type predict_console(logic [1:0] fn, logic [7:0] code,
                                                         logic [IDX_W-1:0] idx);
      console_reply_type r;
      r = '0;
      case (fn)
         FUNC_WRITE: apply_code(code);
         FUNC_CLEAR: blank_grid();
         FUNC_READ: begin
            if (idx < CELLS) begin
               r.glyph = glyph_mem[idx];
               r.tint  = tint_mem[idx];
            end
         end
         default: ;
      endcase
      r.pos = POS_W'(cur_row * COLUMNS + cur_col);
      return r;
   endfunction

   always @(posedge clock) begin
      console_reply_type want;
      console_reply_type got;
      if (reset) begin
         fill_tint = RESET_COLOR;
         blank_grid();
         console_replies.delete();
      end else begin
         if (csr_wr_en) fill_tint = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[10:0], rsp_tdata[18:11], rsp_tdata[26:19]};
            if (console_replies.size() == 0) begin
               mismatches++;
               $display("%0t: response transfer with no request waiting, got %h",
                        $time, rsp_tdata);
            end else begin
               want = console_replies.pop_front();
               if (got.pos !== want.pos) begin
                  mismatches++;
                  $display("%0t: cursor_pos expected %0d, got %0d",
                           $time, want.pos, got.pos);
               end
               if (got.glyph !== want.glyph) begin
                  mismatches++;
                  $display("%0t: read_char expected %h, got %h",
                           $time, want.glyph, got.glyph);
               end
               if (got.tint !== want.tint) begin
                  mismatches++;
                  $display("%0t: read_color expected %h, got %h",
                           $time, want.tint, got.tint);
               end
            end
         end
         if (req_tvalid && req_tready)
            console_replies.push_back(predict_console(req_tuser, req_tdata[7:0],
                                                      req_tdata[18:8]));
      end
      pending    <= console_replies.size();
      fail_count <= mismatches;
   end

endmodule

[dv/text_console_writer_test.sv]
// Top of the text console writer testbench: clock, reset, request and
// response drivers, fill color writes and the verdict.
// Depends on tcw_pkg, text_console_writer and text_console_checker.
`timescale 1ns / 100ps

module text_console_writer_test;
   import tcw_pkg::*;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int QUIET_LIMIT   = 20000;
   localparam int STALL_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 105;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = FUNC_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   int pending;
   int fail_count;
   int idle_run = 0;
   bit quiet_mode = 1'b0;
   bit stall_pending = 1'b0;

   always #5 clock = ~clock;

   text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   text_console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .pending    (pending),
      .fail_count (fail_count)
   );

   // Response side: random back-pressure, or one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_pending) begin
            stall_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (STALL_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= quiet_mode || ($urandom_range(99) >= 15);
         end
      end
   end

   // Ends the run when no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_run <= 0;
      end else if (idle_run >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   task automatic send_item(logic [1:0] fn, logic [7:0] code, logic [IDX_W-1:0] idx);
      while (!quiet_mode && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {5'd0, idx, code};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering and waits until every response has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_fill(logic [7:0] tint);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= tint;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly text writes; the newline share decides between wrapping and scrolling.
   task automatic random_item(int unsigned newline_pct);
      int unsigned pick;
      int unsigned sub;
      logic [IDX_W-1:0] idx;
      pick = $urandom_range(999);
      idx  = IDX_W'($urandom_range(2047));
      if (pick < 5) begin
         send_item(FUNC_CLEAR, 8'($urandom_range(255)), idx);
      end else if (pick < 20) begin
         send_item(FUNC_NONE, 8'($urandom_range(255)), idx);
      end else if (pick < 200) begin
         sub = $urandom_range(9);
         if (sub == 0)
            idx = IDX_W'($urandom_range(2047, COLUMNS * ROWS));
         else if (sub < 5)
            idx = IDX_W'($urandom_range(COLUMNS * ROWS - 1, (ROWS - 3) * COLUMNS));
         else
            idx = IDX_W'($urandom_range(COLUMNS * ROWS - 1));
         send_item(FUNC_READ, 8'($urandom_range(255)), idx);
      end else if (pick < 200 + newline_pct * 10) begin
         send_item(FUNC_WRITE, CODE_NEWLINE, idx);
      end else begin
         sub = $urandom_range(99);
         if (sub < 8)
            send_item(FUNC_WRITE, CODE_RETURN, idx);
         else if (sub < 22)
            send_item(FUNC_WRITE, CODE_TAB, idx);
         else
            send_item(FUNC_WRITE, 8'($urandom_range(255)), idx);
      end
   endtask

   initial begin
      logic [7:0] tints [6];
      tints = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255))};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset contents and out-of-range reads, then tab stops, return and newline on the top rows, then a clear.
      send_item(FUNC_READ, 8'h00, 11'd0);
      send_item(FUNC_READ, 8'hFF, 11'd1999);
      send_item(FUNC_READ, 8'h00, 11'd2047);
      send_item(FUNC_READ, 8'h00, 11'd2000);
      send_item(FUNC_NONE, 8'hFF, 11'd2047);
      send_item(FUNC_WRITE, 8'h00, 11'd2047);
      send_item(FUNC_WRITE, 8'hFF, 11'd0);
      send_item(FUNC_WRITE, 8'h41, 11'd0);
      send_item(FUNC_WRITE, CODE_TAB, 11'd0);
      send_item(FUNC_WRITE, CODE_TAB, 11'd0);
      send_item(FUNC_WRITE, CODE_RETURN, 11'd0);
      send_item(FUNC_WRITE, 8'h42, 11'd0);
      send_item(FUNC_WRITE, CODE_TAB, 11'd0);
      send_item(FUNC_WRITE, CODE_NEWLINE, 11'd0);
      send_item(FUNC_WRITE, 8'h55, 11'd0);
      send_item(FUNC_READ, 8'h00, 11'd0);
      send_item(FUNC_READ, 8'h00, 11'd1);
      send_item(FUNC_READ, 8'h00, 11'd3);
      send_item(FUNC_READ, 8'h00, 11'd80);
      send_item(FUNC_CLEAR, 8'h00, 11'd0);
      send_item(FUNC_READ, 8'h00, 11'd1);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         set_fill(tints[ph]);
         quiet_mode = (ph == 2);
         if (ph == 3) stall_pending = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            random_item((ph % 2 == 0) ? 15 : 1);
      end
      quiet_mode = 1'b0;

      drain();
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
